// File: rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB translator package
// Shared widths and default parameter values for the address translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Width of a logical and of a physical address.
  localparam int unsigned AddrW = 16;

  // Width of the running transaction counters.
  localparam int unsigned CountW = 32;

  // Default geometry.
  localparam int unsigned TlbEntriesDef = 16;
  localparam int unsigned PageBitsDef   = 8;

endpackage

// File: rtl/tpt_cell.sv
// ----------------------------------------------------------------------------
// TLB cell
// One TLB slot of the replacement chain. On a shift it takes the entry of its
// upstream neighbour, so the chain ages out its oldest entry in FIFO order.
// ----------------------------------------------------------------------------
module tpt_cell
  import tpt_pkg::*;
#(
  parameter int unsigned VpnW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            valid_i,
  input  logic [VpnW-1:0] page_i,
  input  logic [VpnW-1:0] frame_i,
  input  logic [VpnW-1:0] look_page_i,
  output logic            valid_o,
  output logic [VpnW-1:0] page_o,
  output logic [VpnW-1:0] frame_o,
  output logic            match_o,
  output logic [VpnW-1:0] match_frame_o
);

  logic            valid_q;
  logic [VpnW-1:0] page_q;
  logic [VpnW-1:0] frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      page_q  <= page_i;
      frame_q <= frame_i;
    end
  end

  assign match_o       = valid_q && (page_q == look_page_i);
  assign match_frame_o = match_o ? frame_q : '0;

  assign valid_o = valid_q;
  assign page_o  = page_q;
  assign frame_o = frame_q;

endmodule

// File: rtl/tpt_page_table.sv
// ----------------------------------------------------------------------------
// Page table
// One entry per page holding a mapped flag and a frame number. After reset a
// sweep clears every entry, one per cycle; reads are registered.
// ----------------------------------------------------------------------------
module tpt_page_table
  import tpt_pkg::*;
#(
  parameter int unsigned VpnW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [VpnW-1:0] rd_page_i,
  input  logic            wr_en_i,
  input  logic [VpnW-1:0] wr_page_i,
  input  logic [VpnW-1:0] wr_frame_i,
  output logic            rd_valid_o,
  output logic [VpnW-1:0] rd_frame_o,
  output logic            ready_o
);

  localparam int unsigned Pages = 1 << VpnW;

  logic [VpnW:0]   mem_q [Pages];
  logic [VpnW:0]   rd_q;
  logic            clearing_q;
  logic [VpnW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == {VpnW{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_page_i] <= {1'b1, wr_frame_i};
    end
    rd_q <= mem_q[rd_page_i];
  end

  assign rd_valid_o = rd_q[VpnW];
  assign rd_frame_o = rd_q[VpnW-1:0];
  assign ready_o    = !clearing_q;

endmodule

// File: rtl/tlb_page_table_translate.sv
// ----------------------------------------------------------------------------
// TLB address translator
// Translates logical addresses to physical ones through a FIFO-replaced TLB
// backed by a demand-paged page table.
// ----------------------------------------------------------------------------
// Usage. A transaction is accepted on the rising edge where start is high and
// busy is low; logical_address_i carries the address. Its result appears on
// the result ports for exactly one cycle, flagged by valid_o, once the lookup
// state has registered it. The receiver cannot stall, so results are simply
// taken. The page table read is registered: the entry is fetched as the
// address is accepted, and the lookup state then compares the page against
// every TLB cell, resolves the frame and commits any update. busy stays high
// during the lookup and is low again in the cycle the result is shown, so a
// new address may be started then.
// The TLB is a row of cells; on every miss a new entry is shifted in at the
// head and the oldest drops off the tail, giving FIFO replacement.
// Reset clears the TLB cells and the counters at once, and then the page table
// is swept clear one entry a cycle over its 2**(16 - PAGE_BITS) entries
// (256 by default). busy stays high throughout that sweep.
// ----------------------------------------------------------------------------
module tlb_page_table_translate
  import tpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = TlbEntriesDef,
  parameter int unsigned PAGE_BITS   = PageBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [AddrW-1:0]  logical_address_i,
  output logic              valid_o,
  output logic [AddrW-1:0]  physical_address_o,
  output logic              tlb_hit_o,
  output logic              page_fault_o,
  output logic [CountW-1:0] address_count_o,
  output logic [CountW-1:0] hit_count_o,
  output logic [CountW-1:0] fault_count_o
);

  localparam int unsigned VpnW = AddrW - PAGE_BITS;

  typedef enum logic {
    StIdle,
    StLook
  } state_e;

  state_e state_q;

  logic [AddrW-1:0]  addr_q;
  logic [VpnW-1:0]   next_free_q;
  logic [CountW-1:0] addr_cnt_q;
  logic [CountW-1:0] hit_cnt_q;
  logic [CountW-1:0] fault_cnt_q;
  logic              valid_q;
  logic [AddrW-1:0]  phys_q;
  logic              hit_q;
  logic              fault_q;

  logic [VpnW-1:0] look_page;
  logic            accept;
  logic            pt_ready;
  logic            pt_valid;
  logic [VpnW-1:0] pt_frame;

  // The TLB chain: entry i+1 of these arrays is the output of cell i, and the
  // extra head entry 0 is the one being inserted.
  logic            chain_valid [TLB_ENTRIES+1];
  logic [VpnW-1:0] chain_page  [TLB_ENTRIES+1];
  logic [VpnW-1:0] chain_frame [TLB_ENTRIES+1];
  logic [TLB_ENTRIES-1:0] cell_match;
  logic [VpnW-1:0] cell_frame  [TLB_ENTRIES];

  logic            hit;
  logic            fault;
  logic            shift;
  logic [VpnW-1:0] tlb_frame;
  logic [VpnW-1:0] frame;

  assign look_page = addr_q[AddrW-1:PAGE_BITS];
  assign busy      = !pt_ready || (state_q == StLook);
  assign accept    = start && !busy;

  // Page table, read with the page of the incoming address so that the entry
  // is ready in the lookup cycle.
  tpt_page_table #(
    .VpnW(VpnW)
  ) u_page_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_page_i  (logical_address_i[AddrW-1:PAGE_BITS]),
    .wr_en_i    (fault),
    .wr_page_i  (look_page),
    .wr_frame_i (next_free_q),
    .rd_valid_o (pt_valid),
    .rd_frame_o (pt_frame),
    .ready_o    (pt_ready)
  );

  assign chain_valid[0] = 1'b1;
  assign chain_page[0]  = look_page;
  assign chain_frame[0] = frame;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tpt_cell #(
      .VpnW(VpnW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (shift),
      .valid_i       (chain_valid[i]),
      .page_i        (chain_page[i]),
      .frame_i       (chain_frame[i]),
      .look_page_i   (look_page),
      .valid_o       (chain_valid[i+1]),
      .page_o        (chain_page[i+1]),
      .frame_o       (chain_frame[i+1]),
      .match_o       (cell_match[i]),
      .match_frame_o (cell_frame[i])
    );
  end

  // A page sits in at most one cell, so the gated frames can simply be ORed.
  always_comb begin
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_frame = tlb_frame | cell_frame[i];
    end
  end

  assign hit   = |cell_match;
  assign fault = (state_q == StLook) && !hit && !pt_valid;
  assign shift = (state_q == StLook) && !hit;

  always_comb begin
    if (hit) begin
      frame = tlb_frame;
    end else if (pt_valid) begin
      frame = pt_frame;
    end else begin
      frame = next_free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= 1'b0;
      next_free_q <= '0;
      addr_cnt_q  <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      addr_q      <= '0;
      phys_q      <= '0;
      hit_q       <= 1'b0;
      fault_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            addr_q  <= logical_address_i;
            state_q <= StLook;
          end
        end
        StLook: begin
          valid_q    <= 1'b1;
          phys_q     <= {frame, addr_q[PAGE_BITS-1:0]};
          hit_q      <= hit;
          fault_q    <= fault;
          addr_cnt_q <= addr_cnt_q + 1'b1;
          if (hit) begin
            hit_cnt_q <= hit_cnt_q + 1'b1;
          end
          if (fault) begin
            fault_cnt_q <= fault_cnt_q + 1'b1;
            next_free_q <= next_free_q + 1'b1;
          end
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign valid_o            = valid_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign address_count_o    = addr_cnt_q;
  assign hit_count_o        = hit_cnt_q;
  assign fault_count_o      = fault_cnt_q;

endmodule

// File: tb/sv/tlb_page_table_translate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLB address translator testbench
// Feeds logical addresses through the command handshake and checks every
// translation against a local model of the FIFO-replaced TLB and the
// demand-paged page table. The run opens with directed addresses and then
// moves on to random traffic with bursts of locality.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_tb;
  import tpt_pkg::*;

  // The geometry under test is the package default.
  localparam int unsigned TlbEntries = TlbEntriesDef;
  localparam int unsigned PageBits   = PageBitsDef;
  localparam int unsigned PageNumW   = AddrW - PageBits;
  localparam int unsigned NumPages   = 1 << PageNumW;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RandomTxns = 1750;

  typedef logic [PageNumW-1:0] page_t;

  // One translation as the block reports it.
  typedef struct packed {
    logic [AddrW-1:0]  phys_addr;
    logic              tlb_hit;
    logic              page_fault;
    logic [CountW-1:0] addr_cnt;
    logic [CountW-1:0] hit_cnt;
    logic [CountW-1:0] fault_cnt;
  } xlate_t;

  // An address waiting to be sent. When drain_first is set the sender holds
  // it back until every transaction in flight has returned its result.
  typedef struct {
    logic [AddrW-1:0] addr;
    bit               drain_first;
  } lookup_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [AddrW-1:0]  logical_address = '0;
  logic              valid_o;
  logic [AddrW-1:0]  physical_address_o;
  logic              tlb_hit_o;
  logic              page_fault_o;
  logic [CountW-1:0] address_count_o;
  logic [CountW-1:0] hit_count_o;
  logic [CountW-1:0] fault_count_o;

  tlb_page_table_translate #(
    .TLB_ENTRIES (TlbEntries),
    .PAGE_BITS   (PageBits)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .logical_address_i  (logical_address),
    .valid_o            (valid_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .address_count_o    (address_count_o),
    .hit_count_o        (hit_count_o),
    .fault_count_o      (fault_count_o)
  );

  // --------------------------------------------------------------------------
  // Local model of the translator.
  // The TLB is kept as an array of slots with a replacement pointer. The block
  // itself shifts entries along a row of cells, but as a page only enters the
  // TLB after it missed, no page is ever held twice and both views agree on
  // every lookup and on which entry is the oldest.
  // --------------------------------------------------------------------------
  bit                tlb_slot_used [TlbEntries];
  page_t             tlb_slot_page [TlbEntries];
  page_t             tlb_slot_frame[TlbEntries];
  bit                pt_mapped     [NumPages];
  page_t             pt_frame      [NumPages];
  int unsigned       replace_ptr   = 0;
  page_t             free_frame    = '0;
  logic [CountW-1:0] xlate_total   = '0;
  logic [CountW-1:0] hit_total     = '0;
  logic [CountW-1:0] fault_total   = '0;
  int unsigned       table_hit_total = 0;

  function automatic xlate_t translate_address(logic [AddrW-1:0] la);
    xlate_t res;
    page_t  page;
    page_t  frame;
    bit     hit;
    bit     fault;
    page  = la[AddrW-1:PageBits];
    frame = '0;
    hit   = 1'b0;
    fault = 1'b0;
    xlate_total = xlate_total + 1'b1;
    // Fully associative compare; the lowest matching slot would win.
    for (int i = 0; i < TlbEntries; i++) begin
      if (!hit && tlb_slot_used[i] && tlb_slot_page[i] == page) begin
        hit   = 1'b1;
        frame = tlb_slot_frame[i];
      end
    end
    if (hit) begin
      hit_total = hit_total + 1'b1;
    end else begin
      if (pt_mapped[page]) begin
        frame = pt_frame[page];
        table_hit_total++;
      end else begin
        // Demand paging: the page takes the next frame in order.
        fault           = 1'b1;
        fault_total     = fault_total + 1'b1;
        frame           = free_frame;
        pt_frame[page]  = frame;
        pt_mapped[page] = 1'b1;
        free_frame      = free_frame + 1'b1;
      end
      tlb_slot_used[replace_ptr]  = 1'b1;
      tlb_slot_page[replace_ptr]  = page;
      tlb_slot_frame[replace_ptr] = frame;
      replace_ptr = (replace_ptr + 1 >= TlbEntries) ? 0 : replace_ptr + 1;
    end
    res.phys_addr  = {frame, la[PageBits-1:0]};
    res.tlb_hit    = hit;
    res.page_fault = fault;
    res.addr_cnt   = xlate_total;
    res.hit_cnt    = hit_total;
    res.fault_cnt  = fault_total;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is released once and is never asserted again.
  // --------------------------------------------------------------------------
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver. Addresses are taken from addr_q in order. The sender works in
  // bursts of random length separated by random gaps; while start is high and
  // the block is busy the transaction is simply held. Start is assigned at
  // most once per edge, so a back-to-back transaction keeps it high.
  // --------------------------------------------------------------------------
  lookup_req_t       addr_q[$];
  lookup_req_t       next_req;
  int unsigned       burst_left = 0;
  int unsigned       gap_left   = 0;
  int unsigned       accepted_count = 0;
  int unsigned       result_count   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy) begin
        // Transaction still waiting for the block; hold it.
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (addr_q.size() == 0 ||
                   (addr_q[0].drain_first &&
                    (start || accepted_count != result_count))) begin
        // Either nothing is left to send, or the next address must wait until
        // the block has returned every result owed, the one accepted at this
        // very edge included.
        start <= 1'b0;
      end else begin
        next_req = addr_q.pop_front();
        start           <= 1'b1;
        logical_address <= next_req.addr;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Accepted transactions are predicted here, in the same process
  // that checks results, so the queue of owed translations is only ever
  // touched by one block. The receiver cannot stall, so every strobe is taken.
  // --------------------------------------------------------------------------
  xlate_t      owed_q[$];
  xlate_t      want;
  xlate_t      got;
  int unsigned error_count = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        owed_q.push_back(translate_address(logical_address));
        accepted_count <= accepted_count + 1;
      end
      if (valid_o) begin
        result_count <= result_count + 1;
        got.phys_addr  = physical_address_o;
        got.tlb_hit    = tlb_hit_o;
        got.page_fault = page_fault_o;
        got.addr_cnt   = address_count_o;
        got.hit_cnt    = hit_count_o;
        got.fault_cnt  = fault_count_o;
        if (owed_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: result with no transaction outstanding: phys %h", $realtime,
                     got.phys_addr);
          end
        end else begin
          want = owed_q.pop_front();
          if (got.phys_addr !== want.phys_addr || got.tlb_hit !== want.tlb_hit ||
              got.page_fault !== want.page_fault || got.addr_cnt !== want.addr_cnt ||
              got.hit_cnt !== want.hit_cnt || got.fault_cnt !== want.fault_cnt) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("%0t: mismatch on translation %0d", $realtime, want.addr_cnt);
              $display("  expected phys %h hit %b fault %b counts %0d/%0d/%0d",
                       want.phys_addr, want.tlb_hit, want.page_fault,
                       want.addr_cnt, want.hit_cnt, want.fault_cnt);
              $display("  actual   phys %h hit %b fault %b counts %0d/%0d/%0d",
                       got.phys_addr, got.tlb_hit, got.page_fault,
                       got.addr_cnt, got.hit_cnt, got.fault_cnt);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  task automatic queue_lookup(logic [AddrW-1:0] addr, bit drain_first);
    lookup_req_t req;
    req.addr        = addr;
    req.drain_first = drain_first;
    addr_q.push_back(req);
  endtask

  initial begin
    page_t       hot_pages[$];
    int unsigned hot_size;
    int unsigned run_len;
    int unsigned total;
    int unsigned pick;
    logic [AddrW-1:0] la;

    // Directed part. Page 0 faults and takes frame 0, the repeat on the same
    // page hits with the largest offset, and the top page faults into frame 1.
    queue_lookup(16'h0000, 1'b0);
    queue_lookup(16'h00FF, 1'b0);
    queue_lookup(16'hFFFF, 1'b0);
    queue_lookup(16'hFF00, 1'b0);
    queue_lookup(16'h8001, 1'b0);
    queue_lookup(16'h7FFE, 1'b0);
    // Thirteen further new pages fill the TLB and wrap the replacement
    // pointer, so the oldest entry, page 0, is pushed out.
    for (int p = 1; p <= 13; p++) begin
      queue_lookup({8'(p), 8'(p * 19)}, 1'b0);
    end
    // Page 0 now misses the TLB but is found in the page table; going back in
    // evicts the top page, which is then also a page-table hit.
    queue_lookup(16'h00AA, 1'b0);
    queue_lookup(16'h0055, 1'b0);
    queue_lookup(16'hFF80, 1'b0);

    // Random part. Most traffic comes in runs with locality: a small set of
    // hot pages that mostly hit, sometimes larger than the TLB so that the
    // page table is exercised. The rest is uniform noise over all addresses.
    // The first address of the random part waits for the directed part to
    // drain completely, and so does one in the middle.
    total = 0;
    while (total < RandomTxns) begin
      hot_pages.delete();
      hot_size = ($urandom_range(0, 2) == 0) ? $urandom_range(17, 48)
                                             : $urandom_range(1, 14);
      for (int i = 0; i < hot_size; i++) begin
        hot_pages.push_back(page_t'($urandom_range(0, NumPages - 1)));
      end
      run_len = $urandom_range(10, 60);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          la = AddrW'($urandom());
        end else begin
          pick = $urandom_range(0, hot_size - 1);
          la   = {hot_pages[pick], PageBits'($urandom())};
        end
        queue_lookup(la, total == 0 || total == RandomTxns / 2);
        total++;
      end
    end

    // Wait for every address to be sent and every result to come back.
    while (addr_q.size() != 0 || start || accepted_count != result_count) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);

    $display("Translated %0d addresses: %0d TLB hits, %0d page-table hits, %0d faults",
             accepted_count, hit_total, table_hit_total, fault_total);
    $display("Page faults mapped %0d of %0d pages; directed eviction and drain pauses run",
             fault_total, NumPages);
    if (error_count == 0 && owed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", error_count, owed_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, page-table sweep included.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", accepted_count - result_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
